FILE: hw/rtl/kbsf_pkg.sv
package kbsf_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    localparam int CODE_W  = 8;
    localparam int SCAN_W  = 7;
    localparam int CTRL_W  = 8;

    // control byte fields
    localparam logic [CTRL_W-1:0] CTRL_RESET_MASK = 8'h01;
    localparam logic [CTRL_W-1:0] CTRL_CLOCK_MASK = 8'h02;
    localparam int CTRL_CLOCK_BIT  = 1;
    localparam int CTRL_IRQ_EN_BIT = 2;

    // status byte fields
    localparam int STATUS_NONEMPTY_BIT = 0;
    localparam int STATUS_IRQ_EN_BIT   = 6;
    localparam logic [CODE_W-1:0] STATUS_CLOCK_TOGGLED = 8'h01;

    typedef enum logic [1:0] {
        MODE_KEY    = 2'd0,
        MODE_CTRL   = 2'd1,
        MODE_STATUS = 2'd2,
        MODE_DATA   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] read_value;
        logic              irq_pending;
    } result_t;

    // scan number reversed across the byte, release flag in bit 0
    function automatic logic [CODE_W-1:0] make_code(input logic [SCAN_W-1:0] scan,
                                                    input logic              rel);
        logic [CODE_W-1:0] c;
        c = '0;
        for (int i = 0; i < SCAN_W; i++) begin
            c[CODE_W-1-i] = scan[i];
        end
        c[0] = rel;
        return c;
    endfunction

endpackage

FILE: hw/rtl/kbsf_code_ram.sv
module kbsf_code_ram #(
    parameter int DEPTH  = kbsf_pkg::BUFFER_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  kbsf_pkg::ram_cmd_t          cmd,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [kbsf_pkg::CODE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [kbsf_pkg::CODE_W-1:0] rd_data
);

    logic [kbsf_pkg::CODE_W-1:0] mem [DEPTH];
    logic [kbsf_pkg::CODE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/kbsf_ctrl.sv
module kbsf_ctrl #(
    parameter int DEPTH  = kbsf_pkg::BUFFER_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [kbsf_pkg::SCAN_W-1:0] s_scan_number,
    input  logic                        s_released,
    input  logic [kbsf_pkg::CTRL_W-1:0] s_write_value,
    input  logic                        out_free,
    output kbsf_pkg::result_t           res,
    output kbsf_pkg::ram_cmd_t          ram_cmd,
    output logic [ADDR_W-1:0]           ram_wr_addr,
    output logic [kbsf_pkg::CODE_W-1:0] ram_wr_data,
    output logic [ADDR_W-1:0]           ram_rd_addr,
    input  logic [kbsf_pkg::CODE_W-1:0] ram_rd_data
);

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    kbsf_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    logic [kbsf_pkg::CTRL_W-1:0] ctrl_now_reg, ctrl_now_next;
    logic [kbsf_pkg::CTRL_W-1:0] ctrl_before_reg, ctrl_before_next;

    // captured beat
    kbsf_pkg::mode_t             mode_reg;
    logic [kbsf_pkg::SCAN_W-1:0] scan_reg;
    logic                        rel_reg;
    logic [kbsf_pkg::CTRL_W-1:0] wv_reg;

    logic accept;
    logic do_exec;
    logic nonempty;
    logic [ADDR_W-1:0] head_inc, tail_inc;

    assign accept   = s_valid && s_ready;
    assign do_exec  = (state_reg == kbsf_pkg::ST_EXEC) && out_free;
    assign nonempty = head_reg != tail_reg;
    assign head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kbsf_pkg::ST_CLEAR: begin
                if (clr_idx_reg == LAST) begin
                    state_next = kbsf_pkg::ST_IDLE;
                end
            end
            kbsf_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = kbsf_pkg::ST_EXEC;
                end
            end
            kbsf_pkg::ST_EXEC: begin
                if (out_free) begin
                    state_next = kbsf_pkg::ST_IDLE;
                end
            end
            default: state_next = kbsf_pkg::ST_CLEAR;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready          = state_reg == kbsf_pkg::ST_IDLE;
        ram_cmd.rd_en    = accept;
        ram_cmd.wr_en    = 1'b0;
        ram_rd_addr      = head_reg;
        ram_wr_addr      = tail_reg;
        ram_wr_data      = kbsf_pkg::make_code(scan_reg, rel_reg);
        head_next        = head_reg;
        tail_next        = tail_reg;
        ctrl_now_next    = ctrl_now_reg;
        ctrl_before_next = ctrl_before_reg;
        clr_idx_next     = clr_idx_reg;
        res.valid        = do_exec;
        res.read_value   = '0;

        if (state_reg == kbsf_pkg::ST_CLEAR) begin
            ram_cmd.wr_en = 1'b1;
            ram_wr_addr   = clr_idx_reg;
            ram_wr_data   = '0;
            clr_idx_next  = clr_idx_reg + 1'b1;
        end

        if (do_exec) begin
            case (mode_reg)
                kbsf_pkg::MODE_KEY: begin
                    // full buffer drops the event
                    if (scan_reg != '0 && tail_inc != head_reg) begin
                        ram_cmd.wr_en = 1'b1;
                        tail_next     = tail_inc;
                    end
                end
                kbsf_pkg::MODE_CTRL: begin
                    ctrl_before_next = ctrl_now_reg;
                    ctrl_now_next    = wv_reg;
                    if ((wv_reg & ~kbsf_pkg::CTRL_CLOCK_MASK) == '0) begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    if ((wv_reg & (kbsf_pkg::CTRL_RESET_MASK | kbsf_pkg::CTRL_CLOCK_MASK))
                            == (kbsf_pkg::CTRL_RESET_MASK | kbsf_pkg::CTRL_CLOCK_MASK)
                        && nonempty) begin
                        head_next = head_inc;
                    end
                end
                kbsf_pkg::MODE_STATUS: begin
                    if (ctrl_before_reg[kbsf_pkg::CTRL_CLOCK_BIT]
                        != ctrl_now_reg[kbsf_pkg::CTRL_CLOCK_BIT]) begin
                        res.read_value = kbsf_pkg::STATUS_CLOCK_TOGGLED;
                    end else begin
                        res.read_value[kbsf_pkg::STATUS_NONEMPTY_BIT] = nonempty;
                        res.read_value[kbsf_pkg::STATUS_IRQ_EN_BIT] =
                            ctrl_now_reg[kbsf_pkg::CTRL_IRQ_EN_BIT];
                    end
                end
                kbsf_pkg::MODE_DATA: begin
                    res.read_value = ram_rd_data;
                end
                default: res.read_value = '0;
            endcase
        end

        res.irq_pending = ctrl_now_next[kbsf_pkg::CTRL_IRQ_EN_BIT] && (head_next != tail_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= kbsf_pkg::ST_CLEAR;
            head_reg        <= '0;
            tail_reg        <= '0;
            clr_idx_reg     <= '0;
            ctrl_now_reg    <= '0;
            ctrl_before_reg <= '0;
        end else begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            clr_idx_reg     <= clr_idx_next;
            ctrl_now_reg    <= ctrl_now_next;
            ctrl_before_reg <= ctrl_before_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= kbsf_pkg::mode_t'(s_mode);
            scan_reg <= s_scan_number;
            rel_reg  <= s_released;
            wv_reg   <= s_write_value;
        end
    end

    // pointers must stay in range for non power of two depths
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= LAST && tail_reg <= LAST)
        else $error("pointer out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kbsf_pkg::ST_CLEAR |-> !res.valid && !s_ready)
        else $error("activity during clear");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == kbsf_pkg::ST_EXEC)
        else $error("accepted beat not executed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_exec && ram_cmd.wr_en) |=> tail_reg != $past(tail_reg))
        else $error("push without tail advance");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.irq_pending) |-> ctrl_now_next[kbsf_pkg::CTRL_IRQ_EN_BIT])
        else $error("irq without enable");

endmodule

FILE: hw/rtl/keyboard_scan_fifo_interface.sv
// Keyboard scan-code FIFO interface.
//
// Input channel (s_*): one beat is a key event or a bus access, chosen by
// s_mode (key event, control write, status read, data read). Key events push
// a bit-reversed scan code into a ring buffer of BUFFER_DEPTH entries; a full
// buffer drops the event. Output channel (m_*): exactly one result beat per
// input beat, carrying the read byte (0 for key events and control writes)
// and the interrupt-pending flag after that beat.
//
// Timing: a beat is accepted in IDLE and executed in EXEC once the output
// register is free (the buffer RAM read of the head entry, started at
// acceptance, has landed by then); the result is registered, so m_valid
// rises in the cycle after execution. The controller takes no new beat
// until the last one has executed. The output register lets the next beat
// be accepted while a result waits; if the receiver stalls, execution of
// that next beat holds until the output register frees up.
//
// Reset: synchronous, active low. Afterwards a clearing pass writes zero to
// every buffer entry, with s_ready low.
module keyboard_scan_fifo_interface #(
    parameter int BUFFER_DEPTH = kbsf_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [kbsf_pkg::SCAN_W-1:0] s_scan_number,
    input  logic                        s_released,
    input  logic [kbsf_pkg::CTRL_W-1:0] s_write_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [kbsf_pkg::CODE_W-1:0] m_read_value,
    output logic                        m_irq_pending
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    kbsf_pkg::result_t  res;
    kbsf_pkg::ram_cmd_t ram_cmd;
    logic [ADDR_W-1:0]           ram_wr_addr;
    logic [ADDR_W-1:0]           ram_rd_addr;
    logic [kbsf_pkg::CODE_W-1:0] ram_wr_data;
    logic [kbsf_pkg::CODE_W-1:0] ram_rd_data;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic [kbsf_pkg::CODE_W-1:0] m_read_value_reg;
    logic                        m_irq_pending_reg;
    logic                        out_free;

    assign out_free = !m_valid_reg || m_ready;

    kbsf_ctrl #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_scan_number (s_scan_number),
        .s_released    (s_released),
        .s_write_value (s_write_value),
        .out_free      (out_free),
        .res           (res),
        .ram_cmd       (ram_cmd),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    kbsf_code_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .cmd     (ram_cmd),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result only offered by ctrl when the register is free
    always_comb begin
        if (res.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_read_value_reg  <= res.read_value;
            m_irq_pending_reg <= res.irq_pending;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_irq_pending = m_irq_pending_reg;

endmodule

FILE: tb/sv/kbsf_checker.sv
`timescale 1ns / 100ps

module kbsf_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [kbsf_pkg::SCAN_W-1:0] s_scan_number,
    input  logic                        s_released,
    input  logic [kbsf_pkg::CTRL_W-1:0] s_write_value,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [kbsf_pkg::CODE_W-1:0] m_read_value,
    input  logic                        m_irq_pending,
    output int unsigned                 fail_count,
    output int unsigned                 awaiting
);

    localparam int DEPTH = kbsf_pkg::BUFFER_DEPTH_DEF;
    localparam logic [kbsf_pkg::CTRL_W-1:0] ACK_BITS =
        kbsf_pkg::CTRL_RESET_MASK | kbsf_pkg::CTRL_CLOCK_MASK;

    typedef struct packed {
        logic [kbsf_pkg::CODE_W-1:0] read_value;
        logic                        irq_pending;
    } kb_reply_t;

    // shadow copy of the scan-code ring and control registers
    logic [kbsf_pkg::CODE_W-1:0] code_ram [DEPTH];
    int unsigned                 head_idx;
    int unsigned                 tail_idx;
    logic [kbsf_pkg::CTRL_W-1:0] ctrl_now;
    logic [kbsf_pkg::CTRL_W-1:0] ctrl_prev;
    kb_reply_t                   reply_q [$];
    int unsigned                 errs;

    function automatic int unsigned ring_next(input int unsigned p);
        return (p + 1 == DEPTH) ? 0 : p + 1;
    endfunction

    task automatic predict_reply(input logic [1:0]                  mode,
                                 input logic [kbsf_pkg::SCAN_W-1:0] scan,
                                 input logic                        rel,
                                 input logic [kbsf_pkg::CTRL_W-1:0] wv);
        logic [kbsf_pkg::SCAN_W-1:0] rev;
        logic [kbsf_pkg::CODE_W-1:0] code;
        kb_reply_t                   r;
        r = '0;
        case (kbsf_pkg::mode_t'(mode))
            kbsf_pkg::MODE_KEY: begin
                if (scan != '0) begin
                    rev  = {<<{scan}};
                    code = {rev, rel};
                    // full ring drops the event
                    if (ring_next(tail_idx) != head_idx) begin
                        code_ram[tail_idx] = code;
                        tail_idx = ring_next(tail_idx);
                    end
                end
            end
            kbsf_pkg::MODE_CTRL: begin
                ctrl_prev = ctrl_now;
                ctrl_now  = wv;
                if ((wv & ~kbsf_pkg::CTRL_CLOCK_MASK) == '0) begin
                    head_idx = 0;
                    tail_idx = 0;
                end
                if ((wv & ACK_BITS) == ACK_BITS && head_idx != tail_idx)
                    head_idx = ring_next(head_idx);
            end
            kbsf_pkg::MODE_STATUS: begin
                if (((ctrl_prev ^ ctrl_now) & kbsf_pkg::CTRL_CLOCK_MASK) != '0) begin
                    r.read_value = kbsf_pkg::STATUS_CLOCK_TOGGLED;
                end else begin
                    r.read_value[kbsf_pkg::STATUS_NONEMPTY_BIT] = (head_idx != tail_idx);
                    r.read_value[kbsf_pkg::STATUS_IRQ_EN_BIT]   =
                        ctrl_now[kbsf_pkg::CTRL_IRQ_EN_BIT];
                end
            end
            kbsf_pkg::MODE_DATA: r.read_value = code_ram[head_idx];
            default: ;
        endcase
        r.irq_pending = ctrl_now[kbsf_pkg::CTRL_IRQ_EN_BIT] && (head_idx != tail_idx);
        reply_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        kb_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) code_ram[i] = '0;
            head_idx  = 0;
            tail_idx  = 0;
            ctrl_now  = '0;
            ctrl_prev = '0;
            reply_q.delete();
            errs      = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    $error("result beat with nothing expected: read_value %0h irq_pending %0b",
                           m_read_value, m_irq_pending);
                    errs++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_read_value !== want.read_value) begin
                        $error("read_value: expected %0h, actual %0h",
                               want.read_value, m_read_value);
                        errs++;
                    end
                    if (m_irq_pending !== want.irq_pending) begin
                        $error("irq_pending: expected %0b, actual %0b",
                               want.irq_pending, m_irq_pending);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_reply(s_mode, s_scan_number, s_released, s_write_value);
        end
        fail_count <= errs;
        awaiting   <= $unsigned(reply_q.size());
    end

endmodule

FILE: tb/sv/tb_keyboard_scan_fifo_interface.sv
`timescale 1ns / 100ps

module tb_keyboard_scan_fifo_interface;

    // Control byte values built from the package field masks
    localparam logic [kbsf_pkg::CTRL_W-1:0] CTL_IRQ_EN =
        {{(kbsf_pkg::CTRL_W-1){1'b0}}, 1'b1} << kbsf_pkg::CTRL_IRQ_EN_BIT;
    localparam logic [kbsf_pkg::CTRL_W-1:0] CTL_ACK =
        kbsf_pkg::CTRL_RESET_MASK | kbsf_pkg::CTRL_CLOCK_MASK;

    localparam int RANDOM_BEATS = 1800;
    localparam int FILL_LEN     = 260;   // more than the ring holds
    localparam int SQUEEZE_LEN  = 300;   // receiver hold-off, in cycles

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [1:0]                  s_mode;
    logic [kbsf_pkg::SCAN_W-1:0] s_scan_number;
    logic                        s_released;
    logic [kbsf_pkg::CTRL_W-1:0] s_write_value;
    logic                        m_valid;
    logic                        m_ready;
    logic [kbsf_pkg::CODE_W-1:0] m_read_value;
    logic                        m_irq_pending;

    int unsigned fail_count;
    int unsigned awaiting;

    // Shared between the sender and the receiver; written with NBAs only so
    // the receiver sees a stable value at every falling edge.
    logic calm       = 1'b0;   // no random idling on either side
    logic squeeze_go = 1'b0;   // request for the long receiver hold-off

    int beats_sent = 0;
    int fills      = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    keyboard_scan_fifo_interface u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_scan_number (s_scan_number),
        .s_released    (s_released),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_irq_pending (m_irq_pending)
    );

    kbsf_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_scan_number (s_scan_number),
        .s_released    (s_released),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_irq_pending (m_irq_pending),
        .fail_count    (fail_count),
        .awaiting      (awaiting)
    );

    // random field values at the field widths
    function automatic logic [kbsf_pkg::SCAN_W-1:0] rnd_scan(input int unsigned lo);
        int unsigned r;
        r = $urandom_range(127, lo);
        return r[kbsf_pkg::SCAN_W-1:0];
    endfunction

    function automatic logic rnd_bit();
        int unsigned r;
        r = $urandom_range(1);
        return r[0];
    endfunction

    function automatic logic [kbsf_pkg::CTRL_W-1:0] rnd_byte();
        int unsigned r;
        r = $urandom_range(255);
        return r[kbsf_pkg::CTRL_W-1:0];
    endfunction

    function automatic kbsf_pkg::mode_t rnd_mode();
        int unsigned r;
        r = $urandom_range(3);
        return kbsf_pkg::mode_t'(r[1:0]);
    endfunction

    // Offer one input beat. Called at a falling edge, returns at the falling
    // edge after the beat was taken. Valid stays up between back-to-back beats;
    // a random gap drops it first.
    task automatic offer_beat(input kbsf_pkg::mode_t             mode,
                              input logic [kbsf_pkg::SCAN_W-1:0] scan,
                              input logic                        rel,
                              input logic [kbsf_pkg::CTRL_W-1:0] wv);
        int gap;
        if (!calm && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            gap = int'($urandom_range(3, 1));
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_scan_number <= scan;
        s_released    <= rel;
        s_write_value <= wv;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        beats_sent++;
    endtask

    // Receiver: random back-pressure, none during the calm window, and one
    // long hold-off so the block backs up and drops s_ready.
    initial begin
        bit squeezed;
        squeezed = 1'b0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (squeeze_go && !squeezed) begin
                squeezed = 1'b1;
                m_ready <= 1'b0;
                repeat (SQUEEZE_LEN) @(negedge aclk);
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
            end
        end
    end

    initial begin
        int pick;
        int n;
        logic [kbsf_pkg::CTRL_W-1:0] irq_bit;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = kbsf_pkg::MODE_KEY;
        s_scan_number = '0;
        s_released    = 1'b0;
        s_write_value = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        offer_beat(kbsf_pkg::MODE_DATA,   7'h00, 1'b0, 8'h00);  // ring content after reset
        offer_beat(kbsf_pkg::MODE_STATUS, 7'h00, 1'b0, 8'h00);  // empty, nothing enabled
        offer_beat(kbsf_pkg::MODE_KEY,    7'h00, 1'b1, 8'h00);  // unmapped key: no push
        offer_beat(kbsf_pkg::MODE_KEY,    7'h7F, 1'b1, 8'h00);  // top scan, release
        offer_beat(kbsf_pkg::MODE_KEY,    7'h01, 1'b0, 8'hFF);  // lowest scan, press
        offer_beat(kbsf_pkg::MODE_STATUS, 7'h7F, 1'b1, 8'hFF);
        offer_beat(kbsf_pkg::MODE_DATA,   7'h00, 1'b0, 8'h00);
        offer_beat(kbsf_pkg::MODE_CTRL,   7'h00, 1'b0, CTL_IRQ_EN); // irq on, pointers kept
        offer_beat(kbsf_pkg::MODE_STATUS, 7'h00, 1'b0, 8'h00);  // non-empty plus irq enable
        offer_beat(kbsf_pkg::MODE_CTRL,   7'h00, 1'b0, CTL_ACK | CTL_IRQ_EN); // ack, clock up
        offer_beat(kbsf_pkg::MODE_STATUS, 7'h00, 1'b0, 8'h00);  // clock-toggled answer
        offer_beat(kbsf_pkg::MODE_DATA,   7'h00, 1'b0, 8'h00);
        offer_beat(kbsf_pkg::MODE_CTRL,   7'h00, 1'b0, CTL_ACK);   // ack, ring goes empty
        offer_beat(kbsf_pkg::MODE_DATA,   7'h00, 1'b0, 8'h00);  // stale entry on empty ring
        offer_beat(kbsf_pkg::MODE_STATUS, 7'h00, 1'b0, 8'h00);
        offer_beat(kbsf_pkg::MODE_CTRL,   7'h00, 1'b0, CTL_ACK);   // ack on empty ring
        offer_beat(kbsf_pkg::MODE_KEY,    7'h55, 1'b0, 8'h00);
        offer_beat(kbsf_pkg::MODE_KEY,    7'h2A, 1'b1, 8'h00);
        offer_beat(kbsf_pkg::MODE_CTRL,   7'h00, 1'b0,
                   kbsf_pkg::CTRL_CLOCK_MASK);                  // clock only: pointers clear
        offer_beat(kbsf_pkg::MODE_STATUS, 7'h00, 1'b0, 8'h00);
        offer_beat(kbsf_pkg::MODE_CTRL,   7'h00, 1'b0, 8'hFF);
        offer_beat(kbsf_pkg::MODE_CTRL,   7'h00, 1'b0, 8'h00);  // all clear: pointers clear
        offer_beat(kbsf_pkg::MODE_KEY,    7'h2A, 1'b1, 8'h00);
        offer_beat(kbsf_pkg::MODE_DATA,   7'h00, 1'b0, 8'h00);

        // ---- random part: sequences shaped like a host servicing a keyboard ----
        n = beats_sent + RANDOM_BEATS;
        while (beats_sent < n) begin
            // a stretch with no idling on either side
            calm <= (beats_sent >= 700 && beats_sent < 1000);
            pick = int'($urandom_range(99));
            irq_bit = rnd_bit() ? CTL_IRQ_EN : '0;
            if (pick < 6 && fills < 2) begin
                // typing with nobody reading: ring fills, then drops events;
                // the first one also runs under a long receiver hold-off
                fills++;
                squeeze_go <= 1'b1;
                repeat (FILL_LEN)
                    offer_beat(kbsf_pkg::MODE_KEY, rnd_scan(1), rnd_bit(), rnd_byte());
            end else if (pick < 35) begin
                // burst of key events, an occasional unmapped one
                repeat ($urandom_range(1, 16))
                    offer_beat(kbsf_pkg::MODE_KEY,
                               ($urandom_range(15) == 0) ? 7'h00 : rnd_scan(1),
                               rnd_bit(), rnd_byte());
            end else if (pick < 60) begin
                // service loop: status, data, ack, then at random let the clock fall again
                repeat ($urandom_range(1, 12)) begin
                    offer_beat(kbsf_pkg::MODE_STATUS, rnd_scan(0), rnd_bit(), rnd_byte());
                    offer_beat(kbsf_pkg::MODE_DATA, rnd_scan(0), rnd_bit(), rnd_byte());
                    offer_beat(kbsf_pkg::MODE_CTRL, rnd_scan(0), rnd_bit(),
                               CTL_ACK | irq_bit);
                    if (rnd_bit())
                        offer_beat(kbsf_pkg::MODE_CTRL, rnd_scan(0), rnd_bit(),
                                   kbsf_pkg::CTRL_RESET_MASK | irq_bit);
                end
            end else if (pick < 70) begin
                // drain: read and ack back to back
                repeat ($urandom_range(10, 60)) begin
                    offer_beat(kbsf_pkg::MODE_DATA, rnd_scan(0), rnd_bit(), rnd_byte());
                    offer_beat(kbsf_pkg::MODE_CTRL, rnd_scan(0), rnd_bit(),
                               CTL_ACK | irq_bit);
                end
            end else if (pick < 78) begin
                // interface reset: all clear or clock only
                offer_beat(kbsf_pkg::MODE_CTRL, rnd_scan(0), rnd_bit(),
                           rnd_bit() ? kbsf_pkg::CTRL_CLOCK_MASK : 8'h00);
                offer_beat(kbsf_pkg::MODE_STATUS, rnd_scan(0), rnd_bit(), rnd_byte());
            end else begin
                // noise: any mode, any field value
                repeat ($urandom_range(1, 8))
                    offer_beat(rnd_mode(), rnd_scan(0), rnd_bit(), rnd_byte());
            end
        end

        // ---- drain and verdict ----
        s_valid <= 1'b0;
        calm    <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (clearing pass, gaps, stalls).
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
